FILE: hw/rtl/dvpd_pkg.sv
// Package for the delta varint position decoder: transaction types and coding constants.
// Depends on nothing; used by delta_varint_position_decoder.
`timescale 1ns / 1ps
`default_nettype none

package dvpd_pkg;

	// One byte of the packed delta stream.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_run;
	} byte_item_t;

	// One decoded result.
	typedef struct packed {
		logic [31:0] position;
		logic        has_position;
		logic        run_done;
		logic        stopped_early;
	} result_item_t;

	// Lead byte ranges of the UTF-8 style coding.
	localparam logic [7:0] ASCII_MIN = 8'h00;
	localparam logic [7:0] ASCII_MAX = 8'h7F;
	localparam logic [7:0] LEAD2_MIN = 8'hC2;
	localparam logic [7:0] LEAD2_MAX = 8'hDF;
	localparam logic [7:0] LEAD3_MIN = 8'hE0;
	localparam logic [7:0] LEAD3_MAX = 8'hEF;
	localparam logic [7:0] LEAD4_MIN = 8'hF0;
	localparam logic [7:0] LEAD4_MAX = 8'hF7;

	// Payload masks of the lead bytes.
	localparam logic [7:0] LEAD2_MASK = 8'h1F;
	localparam logic [7:0] LEAD3_MASK = 8'h0F;
	localparam logic [7:0] LEAD4_MASK = 8'h07;

	// Continuation bytes are 10xxxxxx.
	localparam logic [7:0] CONT_MASK = 8'hC0;
	localparam logic [7:0] CONT_TAG  = 8'h80;

	// Overlong 3-byte and 4-byte forms.
	localparam logic [7:0] OVERLONG3_LEAD = 8'hE0;
	localparam logic [7:0] OVERLONG3_MIN  = 8'hA0;
	localparam logic [7:0] OVERLONG4_LEAD = 8'hF0;
	localparam logic [7:0] OVERLONG4_MIN  = 8'h90;

	localparam int unsigned DELTA_W = 21;
	localparam int unsigned POS_W   = 32;

endpackage

`default_nettype wire

FILE: hw/rtl/delta_varint_position_decoder.sv
// Delta varint position decoder: top level with input register, decode logic and result register.
// Depends on dvpd_pkg for the transaction types and the coding constants.
//
//  Channel | Valid         | Stall        | Payload                      | Direction
//  byte    | byte_valid    | byte_stall   | byte_data   (byte_item_t)    | into block
//  result  | result_valid  | result_stall | result_data (result_item_t)  | out of block
//
// One byte is accepted per cycle while byte_stall is low; it goes through the input register,
// the decode stage (single decode state update, 32-bit position adder) and the result register.
// Bytes that produce no result pass the decode stage even while the result register is held.
// Reset (arst_n low) clears the decode state and both valid flags at once.
// A held result register stalls the input register only when its byte yields a result.
`timescale 1ns / 1ps
`default_nettype none

module delta_varint_position_decoder (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   byte_valid,
	output logic                        byte_stall,
	input  wire dvpd_pkg::byte_item_t   byte_data,
	output logic                        result_valid,
	input  wire logic                   result_stall,
	output dvpd_pkg::result_item_t      result_data
);

	// Input register.
	logic                   valid_s1;
	dvpd_pkg::byte_item_t   item_s1;

	// Decode state.
	logic [7:0]                     lead_q;
	logic [dvpd_pkg::DELTA_W-1:0]   partial_q;
	logic [1:0]                     left_q;
	logic [1:0]                     seen_q;
	logic [dvpd_pkg::POS_W-1:0]     pos_q;
	logic                           halted_q;

	// Next state and decode results.
	logic [7:0]                     lead_n;
	logic [dvpd_pkg::DELTA_W-1:0]   partial_n;
	logic [dvpd_pkg::DELTA_W-1:0]   partial_cat;
	logic [dvpd_pkg::DELTA_W-1:0]   delta;
	logic [1:0]                     left_n;
	logic [1:0]                     seen_n;
	logic [dvpd_pkg::POS_W-1:0]     pos_n;
	logic                           halted_n;
	logic                           got;
	logic                           bad;
	logic                           produce;
	logic                           advance;
	logic                           out_free;
	logic                           accept;
	logic [7:0]                     b;
	dvpd_pkg::result_item_t         result_n;

	assign b         = item_s1.data_byte;
	assign out_free  = !result_valid || !result_stall;
	assign produce   = got || item_s1.end_of_run;
	assign advance   = valid_s1 && (!produce || out_free);
	assign byte_stall = valid_s1 && !advance;
	assign accept    = byte_valid && !byte_stall;

	// Decode one byte against the current state.
	always_comb begin
		got         = 1'b0;
		bad         = 1'b0;
		delta       = '0;
		lead_n      = lead_q;
		partial_n   = partial_q;
		left_n      = left_q;
		seen_n      = seen_q;
		halted_n    = halted_q;
		pos_n       = pos_q;
		partial_cat = {partial_q[dvpd_pkg::DELTA_W-7:0], b[5:0]};
		if (!halted_q) begin
			if (left_q == 2'd0) begin
				case (b) inside
					[dvpd_pkg::ASCII_MIN:dvpd_pkg::ASCII_MAX]: begin
						delta = {{(dvpd_pkg::DELTA_W-8){1'b0}}, b};
						got   = 1'b1;
					end
					[dvpd_pkg::LEAD2_MIN:dvpd_pkg::LEAD2_MAX]: begin
						lead_n    = b;
						seen_n    = 2'd0;
						partial_n = {{(dvpd_pkg::DELTA_W-8){1'b0}}, b & dvpd_pkg::LEAD2_MASK};
						left_n    = 2'd1;
					end
					[dvpd_pkg::LEAD3_MIN:dvpd_pkg::LEAD3_MAX]: begin
						lead_n    = b;
						seen_n    = 2'd0;
						partial_n = {{(dvpd_pkg::DELTA_W-8){1'b0}}, b & dvpd_pkg::LEAD3_MASK};
						left_n    = 2'd2;
					end
					[dvpd_pkg::LEAD4_MIN:dvpd_pkg::LEAD4_MAX]: begin
						lead_n    = b;
						seen_n    = 2'd0;
						partial_n = {{(dvpd_pkg::DELTA_W-8){1'b0}}, b & dvpd_pkg::LEAD4_MASK};
						left_n    = 2'd3;
					end
					default: begin
						halted_n = 1'b1;
					end
				endcase
			end else begin
				bad = (b & dvpd_pkg::CONT_MASK) != dvpd_pkg::CONT_TAG;
				if (seen_q == 2'd0) begin
					if (lead_q == dvpd_pkg::OVERLONG3_LEAD && b < dvpd_pkg::OVERLONG3_MIN) begin
						bad = 1'b1;
					end
					if (lead_q == dvpd_pkg::OVERLONG4_LEAD && b < dvpd_pkg::OVERLONG4_MIN) begin
						bad = 1'b1;
					end
				end
				if (bad) begin
					halted_n  = 1'b1;
					left_n    = 2'd0;
					seen_n    = 2'd0;
					partial_n = '0;
				end else begin
					left_n = left_q - 2'd1;
					seen_n = seen_q + 2'd1;
					if (left_n == 2'd0) begin
						delta     = partial_cat;
						got       = 1'b1;
						partial_n = '0;
						seen_n    = 2'd0;
					end else begin
						partial_n = partial_cat;
					end
				end
			end
			if (got) begin
				pos_n = pos_q + {{(dvpd_pkg::POS_W-dvpd_pkg::DELTA_W){1'b0}}, delta};
			end
		end
	end

	// Result item for this byte.
	always_comb begin
		result_n.position      = got ? pos_n : '0;
		result_n.has_position  = got;
		result_n.run_done      = item_s1.end_of_run;
		result_n.stopped_early = item_s1.end_of_run && (halted_n || left_n != 2'd0);
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= byte_data;
		end
	end

	// Decode state; everything is cleared at the end of a run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q    <= '0;
			partial_q <= '0;
			left_q    <= '0;
			seen_q    <= '0;
			pos_q     <= '0;
			halted_q  <= 1'b0;
		end else if (advance) begin
			if (item_s1.end_of_run) begin
				lead_q    <= '0;
				partial_q <= '0;
				left_q    <= '0;
				seen_q    <= '0;
				pos_q     <= '0;
				halted_q  <= 1'b0;
			end else begin
				lead_q    <= lead_n;
				partial_q <= partial_n;
				left_q    <= left_n;
				seen_q    <= seen_n;
				pos_q     <= pos_n;
				halted_q  <= halted_n;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance && produce) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			result_data <= result_n;
		end
	end

`ifndef NO_ASSERTIONS
	// A halted decoder is never inside a multi-byte sequence.
	a_halted_no_seq: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> left_q == 2'd0)
		else $error("halted while a sequence is open");

	// Outside a sequence no continuation bytes are counted.
	a_seen_idle: assert property (@(posedge clk) disable iff (!arst_n)
		left_q == 2'd0 |-> seen_q == 2'd0)
		else $error("continuation count left over");

	// An early stop is only reported with the end of a run.
	a_stop_with_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.stopped_early |-> result_data.run_done)
		else $error("early stop without end of run");

	// Only a byte that yields a result can be held back by the output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> valid_s1 && produce && result_valid && result_stall)
		else $error("input stalled without cause");

	// The position is zero unless a delta was completed.
	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_data.has_position |-> result_data.position == '0)
		else $error("position set without a completed delta");
`endif

endmodule

`default_nettype wire
